/* src/sadu_pkg.sv */
`timescale 1ns / 1ps
// Package: constants, per-unit record and control types for the snow albedo update
package sadu_pkg;

  localparam int UNITS_DEF = 16;
  localparam int UNIT_W    = 4;

  localparam logic [15:0] BARE_RESET  = 16'd11141;
  localparam logic [15:0] FRESH_RESET = 16'd55706;

  localparam logic [19:0] SWE_SNOW     = 20'd500;
  localparam logic [19:0] SWE_DEEP     = 20'd6000;
  localparam logic [19:0] SNOWFALL_MIN = 20'd25;
  localparam logic [19:0] SUM_BIG      = 20'd500;
  localparam logic [19:0] SUM_MAX      = 20'hFFFFF;

  localparam logic signed [17:0] DR_BASE     = 18'sd4653;
  localparam logic signed [17:0] DR_BRIGHT   = 18'sd983;
  localparam logic signed [17:0] DR_DULL     = 18'sd66;
  localparam logic signed [17:0] FRESH_DECAY = 18'sd3277;
  localparam logic signed [17:0] COLD_DECAY  = 18'sd393;
  localparam logic signed [17:0] WARM_DECAY  = 18'sd1311;
  localparam logic signed [17:0] ALB_ZERO    = 18'sd0;

  localparam logic [15:0] A_HIGH = 16'd42599;

  localparam logic signed [13:0] T_COLD_MAX = -14'sd600;
  localparam logic signed [13:0] T_WARM_MIN = -14'sd400;
  localparam logic signed [13:0] T_ZERO     = 14'sd0;
  localparam logic signed [18:0] MT_BASE    = 19'sd6690;

  localparam logic [42:0] Q_THR    = 43'd8984985600;
  localparam logic [9:0]  Q_GAIN   = 10'd522;
  localparam logic [16:0] Q_UNITY  = 17'h10000;

  localparam logic [7:0]  BRIGHT_INT = 8'd131;
  localparam logic [16:0] BRIGHT_REC = 17'd75501;
  localparam int          BRIGHT_SH  = 20;

  localparam logic [8:0] WIN_S_LO = 9'd118;
  localparam logic [8:0] WIN_S_HI = 9'd184;
  localparam logic [8:0] WIN_N_LO = 9'd2;
  localparam logic [8:0] WIN_N_HI = 9'd300;

  localparam logic [7:0] AGE_MAX   = 8'd255;
  localparam logic [7:0] AGE_FRESH = 8'd3;

  typedef enum logic [0:0] {
    REG_BARE  = 1'b0,
    REG_FRESH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] albedo;
    logic        winter;
    logic        melt;
    logic [7:0]  age;
    logic [19:0] sum;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mult;
    logic write;
  } cmd_t;

endpackage

/* src/sadu_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one beat through read, multiply and write-back steps
module sadu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sadu_pkg::cmd_t cmd
);
  import sadu_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          cmd.write     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* src/sadu_dp.sv */
`timescale 1ns / 1ps
// Datapath: unit record store, config registers and the daily albedo arithmetic
module sadu_dp #(
  parameter int UNITS = sadu_pkg::UNITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sadu_pkg::cmd_t      cmd,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_mode,
  input  logic [3:0]          in_unit,
  input  logic                in_day_start,
  input  logic                in_day_end,
  input  logic [15:0]         in_step_snow,
  input  logic                in_new_snow,
  input  logic [19:0]         in_swe,
  input  logic signed [13:0]  in_temp_max,
  input  logic signed [13:0]  in_temp_min,
  input  logic [15:0]         in_direct_radiation,
  input  logic [8:0]          in_day_of_year,
  input  logic                in_southern,
  output logic [15:0]         out_albedo,
  output logic                out_winter_flag,
  output logic                out_melt_flag,
  output logic [3:0]          out_unit_out
);
  import sadu_pkg::*;

  localparam int DEPTH = (UNITS < (1 << UNIT_W)) ? UNITS : (1 << UNIT_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // config
  logic [15:0] bare_alb_r, fresh_alb_r;

  // captured beat
  logic               mode_r, dstart_r, dend_r, new_snow_r, south_r;
  logic [3:0]         unit_r;
  logic [15:0]        step_r, q_r;
  logic [19:0]        swe_r;
  logic signed [13:0] tmax_r, tmin_r;
  logic [8:0]         day_r;

  // read step
  rec_t        store_r [DEPTH];
  rec_t        rec_r;
  logic        inrng_r, win1_r;
  logic [15:0] alb1_r;
  logic [7:0]  age1_r;
  logic [19:0] sum1_r;
  logic [25:0] p1_r;

  // multiply step
  logic [42:0] p2_r;
  logic [15:0] inc_r;

  // result
  logic [15:0] out_albedo_r;
  logic        out_winter_r, out_melt_r;
  logic [3:0]  out_unit_r;

  logic [AW-1:0] idx;
  logic          inrng;
  rec_t          rd;
  logic [20:0]   sum_add;
  logic [19:0]   sum1_nxt;
  logic          season, onset;
  logic [15:0]   alb1_nxt;
  logic          win1_nxt;
  logic [7:0]    age1_nxt;
  logic [25:0]   p1_nxt;

  logic [16:0]   alb_gap;
  logic [42:0]   p2_nxt;
  logic [8:0]    s_lo;
  logic [15:0]   inc_int;
  logic [25:0]   inc_frac;
  logic [15:0]   inc_nxt;

  logic signed [17:0] a_s, bare_s, dr, d_alb, d_tmp;
  logic signed [18:0] tmax_x, tmax10, mt;
  logic [16:0]        a_sum;
  logic [15:0]        bright;
  logic               deep, hi, warm, qlt, qgt, cold_on, w2, melt_c;
  logic               d_win, d_melt;
  rec_t               new_rec, seed_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bare_alb_r  <= BARE_RESET;
      fresh_alb_r <= FRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BARE:  bare_alb_r  <= cfg_wdata;
        REG_FRESH: fresh_alb_r <= cfg_wdata;
        default:   bare_alb_r  <= bare_alb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_mode;
      unit_r     <= in_unit;
      dstart_r   <= in_day_start;
      dend_r     <= in_day_end;
      step_r     <= in_step_snow;
      new_snow_r <= in_new_snow;
      swe_r      <= in_swe;
      tmax_r     <= in_temp_max;
      tmin_r     <= in_temp_min;
      q_r        <= in_direct_radiation;
      day_r      <= in_day_of_year;
      south_r    <= in_southern;
    end
  end

  // read the unit record, update the daily sum, winter onset and snow age
  assign inrng = (32'(unit_r) < UNITS);
  assign idx   = unit_r[AW-1:0];
  assign rd    = store_r[idx];

  always_comb begin
    sum_add  = {1'b0, rd.sum} + {5'd0, step_r};
    if (dstart_r) begin
      sum1_nxt = {4'd0, step_r};
    end else if (sum_add > {1'b0, SUM_MAX}) begin
      sum1_nxt = SUM_MAX;
    end else begin
      sum1_nxt = sum_add[19:0];
    end
    season   = south_r ? (day_r inside {[WIN_S_LO:WIN_S_HI]})
                       : (day_r > WIN_N_HI || day_r < WIN_N_LO);
    onset    = season && (swe_r > SWE_SNOW);
    alb1_nxt = onset ? fresh_alb_r : rd.albedo;
    win1_nxt = onset | rd.winter;
    if (new_snow_r) begin
      age1_nxt = 8'd0;
    end else if (rd.age != AGE_MAX) begin
      age1_nxt = rd.age + 8'd1;
    end else begin
      age1_nxt = rd.age;
    end
    p1_nxt   = {10'd0, q_r} * {16'd0, Q_GAIN};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rec_r   <= rd;
      inrng_r <= inrng;
      alb1_r  <= alb1_nxt;
      win1_r  <= win1_nxt;
      age1_r  <= age1_nxt;
      sum1_r  <= sum1_nxt;
      p1_r    <= p1_nxt;
    end
  end

  // radiation product and fresh-snow brightening increment
  always_comb begin
    alb_gap  = Q_UNITY - {1'b0, alb1_r};
    p2_nxt   = {17'd0, p1_r} * {26'd0, alb_gap};
    s_lo     = sum1_r[8:0];
    inc_int  = {7'd0, s_lo} * {8'd0, BRIGHT_INT};
    inc_frac = {17'd0, s_lo} * {9'd0, BRIGHT_REC};
    inc_nxt  = inc_int + 16'(inc_frac >> BRIGHT_SH);
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      p2_r  <= p2_nxt;
      inc_r <= inc_nxt;
    end
  end

  // daily rules
  always_comb begin
    a_s     = signed'({2'b00, alb1_r});
    bare_s  = signed'({2'b00, bare_alb_r});
    deep    = swe_r > SWE_DEEP;
    hi      = alb1_r >= A_HIGH;
    dr      = deep ? (hi ? DR_BRIGHT : DR_DULL) : DR_BASE;
    tmax_x  = 19'(tmax_r);
    tmax10  = (tmax_x <<< 3) + (tmax_x <<< 1);
    mt      = MT_BASE - signed'({4'd0, day_r, 6'd0});
    warm    = tmax10 > mt;
    qlt     = p2_r < Q_THR;
    qgt     = p2_r > Q_THR;
    cold_on = (tmax_r < T_COLD_MAX) && qlt;
    w2      = (win1_r || cold_on) && !(a_s <= bare_s);
    melt_c  = (tmin_r > T_WARM_MIN) || (qgt && (tmax_r > T_ZERO)) || warm;
    a_sum   = {1'b0, alb1_r} + {1'b0, inc_r};
    if ((sum1_r >= SUM_BIG) || (a_sum > {1'b0, fresh_alb_r})) begin
      bright = fresh_alb_r;
    end else begin
      bright = a_sum[15:0];
    end

    d_alb  = a_s;
    d_win  = win1_r;
    d_melt = 1'b0;
    d_tmp  = a_s;
    if (swe_r == 20'd0) begin
      d_alb = bare_s;
      d_win = 1'b0;
    end else if (sum1_r > SNOWFALL_MIN) begin
      d_alb = signed'({2'b00, bright});
    end else begin
      d_win = w2;
      if (w2) begin
        if (age1_r < AGE_FRESH) begin
          d_tmp = a_s - FRESH_DECAY;
          d_alb = (d_tmp < ALB_ZERO) ? ALB_ZERO : d_tmp;
        end else if (melt_c) begin
          d_tmp  = a_s - dr;
          d_alb  = (d_tmp < bare_s) ? bare_s : d_tmp;
          d_melt = 1'b1;
        end else if (hi) begin
          d_alb = a_s - COLD_DECAY;
        end
      end else begin
        d_tmp  = a_s - WARM_DECAY;
        d_alb  = (d_tmp < bare_s) ? bare_s : d_tmp;
        d_melt = 1'b1;
      end
    end

    seed_rec.albedo = (swe_r > SWE_SNOW) ? fresh_alb_r : bare_alb_r;
    seed_rec.winter = swe_r > SWE_SNOW;
    seed_rec.melt   = 1'b0;
    seed_rec.age    = 8'd0;
    seed_rec.sum    = 20'd0;

    if (!mode_r) begin
      new_rec = seed_rec;
    end else if (!dend_r) begin
      new_rec     = rec_r;
      new_rec.sum = sum1_r;
    end else begin
      new_rec.albedo = d_alb[15:0];
      new_rec.winter = d_win;
      new_rec.melt   = d_melt;
      new_rec.age    = age1_r;
      new_rec.sum    = sum1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_r[i] <= '{albedo: BARE_RESET, winter: 1'b0, melt: 1'b0, age: 8'd0, sum: 20'd0};
      end
    end else if (cmd.write && inrng_r) begin
      store_r[idx] <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_albedo_r <= inrng_r ? new_rec.albedo : 16'd0;
      out_winter_r <= inrng_r && new_rec.winter;
      out_melt_r   <= inrng_r && new_rec.melt;
      out_unit_r   <= unit_r;
    end
  end

  assign out_albedo      = out_albedo_r;
  assign out_winter_flag = out_winter_r;
  assign out_melt_flag   = out_melt_r;
  assign out_unit_out    = out_unit_r;

endmodule

/* src/snow_albedo_daily_update.sv */
`timescale 1ns / 1ps
// Top level: snow albedo daily update, controller plus datapath
// A beat is captured, read, multiplied and written back; write-back waits for a free
// output register. A new beat is taken only after the last is written back, as the
// record read, 26x17 radiation multiply and write-back step share one datapath.
// A waiting result holds in the output register while the next beat is accepted.
// Reset (rst_n low, synchronous): every unit record returns to bare albedo 11141,
// flags, age and daily sum clear, config registers return to their reset values.
module snow_albedo_daily_update #(
  parameter int UNITS = sadu_pkg::UNITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [3:0]         in_unit,
  input  logic               in_day_start,
  input  logic               in_day_end,
  input  logic [15:0]        in_step_snow,
  input  logic               in_new_snow,
  input  logic [19:0]        in_swe,
  input  logic signed [13:0] in_temp_max,
  input  logic signed [13:0] in_temp_min,
  input  logic [15:0]        in_direct_radiation,
  input  logic [8:0]         in_day_of_year,
  input  logic               in_southern,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_albedo,
  output logic               out_winter_flag,
  output logic               out_melt_flag,
  output logic [3:0]         out_unit_out
);
  import sadu_pkg::*;

  cmd_t cmd;

  sadu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sadu_dp #(
    .UNITS (UNITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_mode),
    .in_unit             (in_unit),
    .in_day_start        (in_day_start),
    .in_day_end          (in_day_end),
    .in_step_snow        (in_step_snow),
    .in_new_snow         (in_new_snow),
    .in_swe              (in_swe),
    .in_temp_max         (in_temp_max),
    .in_temp_min         (in_temp_min),
    .in_direct_radiation (in_direct_radiation),
    .in_day_of_year      (in_day_of_year),
    .in_southern         (in_southern),
    .out_albedo          (out_albedo),
    .out_winter_flag     (out_winter_flag),
    .out_melt_flag       (out_melt_flag),
    .out_unit_out        (out_unit_out)
  );

endmodule

/* src/sadu_chk.sv */
`timescale 1ns / 1ps
// Checker: port-level assertions for the snow albedo update, bound to the top level
module sadu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_albedo,
  input logic        out_winter_flag,
  input logic        out_melt_flag,
  input logic [3:0]  out_unit_out
);

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken again before the beat finished");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("ready dropped with no beat taken");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_albedo) &&
      $stable(out_winter_flag) && $stable(out_melt_flag) && $stable(out_unit_out))
    else $error("stalled result beat changed");

endmodule

bind snow_albedo_daily_update sadu_chk u_sadu_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_albedo      (out_albedo),
  .out_winter_flag (out_winter_flag),
  .out_melt_flag   (out_melt_flag),
  .out_unit_out    (out_unit_out)
);
